// ===== sv/pes_pkg.sv =====
// shared types, constants and helper functions of the particle euler step unit
`default_nettype none
package pes_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam logic [15:0] HALF_TURN = 16'd32768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_WB,
      ST_WAITC,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      CSR_LIFETIME,
      CSR_START_DELAY,
      CSR_GRAVITY_XY,
      CSR_SLOWDOWN,
      CSR_ROTATION_RATE,
      CSR_COLOR_RATES,
      CSR_SCALE_RATES,
      CSR_VEL_AS_ROT
   } csr_index_type;

   typedef enum logic [4:0] {
      STEP_COL0,
      STEP_COL1,
      STEP_COL2,
      STEP_COL3,
      STEP_ROT,
      STEP_SCX,
      STEP_SCY,
      STEP_POSX,
      STEP_POSY,
      STEP_GRAVX,
      STEP_GRAVY,
      STEP_SLOWX,
      STEP_QHX,
      STEP_QLX,
      STEP_SLOWY,
      STEP_QHY,
      STEP_QLY
   } step_type;

   typedef struct packed {
      logic start;
      logic busy;
   } cordic_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
      logic signed [31:0] r;
      if (v > 51'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -51'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
      logic signed [15:0] r;
      if (v > 26'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -26'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [11:0] v);
      logic [7:0] r;
      if (v < 12'sd0) begin
         r = 8'd0;
      end else if (v > 12'sd255) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   function automatic logic [15:0] atan_entry(input logic [4:0] i);
      logic [15:0] r;
      unique case (i)
         5'd0: r = 16'd8192;
         5'd1: r = 16'd4836;
         5'd2: r = 16'd2555;
         5'd3: r = 16'd1297;
         5'd4: r = 16'd651;
         5'd5: r = 16'd326;
         5'd6: r = 16'd163;
         5'd7: r = 16'd81;
         5'd8: r = 16'd41;
         5'd9: r = 16'd20;
         5'd10: r = 16'd10;
         5'd11: r = 16'd5;
         5'd12: r = 16'd3;
         5'd13: r = 16'd1;
         5'd14: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/pes_mul.sv =====
// shared signed 34x34 multiplier with registered product
`default_nettype none
module pes_mul (
   input  wire logic               clock,
   input  wire logic signed [33:0] mul_a,
   input  wire logic signed [33:0] mul_b,
   output logic signed [67:0]      prod
);
   logic signed [67:0] prod_ff;
   logic signed [67:0] prod_in;

   assign prod_in = 68'(mul_a) * 68'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

// ===== sv/pes_cordic.sv =====
// iterative cordic atan2 of the velocity vector, one rotation per cycle
`default_nettype none
module pes_cordic #(
   parameter int CORDIC_STEPS = pes_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pes_pkg::cordic_ctl_type ctl_in,
   input  wire logic signed [31:0]   vec_x,
   input  wire logic signed [31:0]   vec_y,
   output pes_pkg::cordic_ctl_type   ctl_out,
   output logic [15:0]               angle
);
   import pes_pkg::*;

   localparam int CW = $clog2(CORDIC_STEPS);

   logic                busy_ff;
   logic [CW-1:0]       cnt_ff;
   logic signed [35:0]  x_ff;
   logic signed [35:0]  y_ff;
   logic [15:0]         z_ff;
   logic signed [35:0]  xs;
   logic signed [35:0]  ys;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (ctl_in.start) begin
         cnt_ff <= '0;
         busy_ff <= !(vec_x == 32'sd0 && vec_y == 32'sd0);
         if (vec_x < 32'sd0) begin
            x_ff <= -36'(vec_x);
            y_ff <= -36'(vec_y);
            z_ff <= HALF_TURN;
         end else begin
            x_ff <= 36'(vec_x);
            y_ff <= 36'(vec_y);
            z_ff <= 16'd0;
         end
      end else if (busy_ff) begin
         if (y_ff > 36'sd0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_entry(5'(cnt_ff));
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_entry(5'(cnt_ff));
         end
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      ctl_out.start = 1'b0;
      ctl_out.busy = busy_ff;
   end

   assign angle = z_ff;
endmodule
`default_nettype wire

// ===== sv/particle_euler_step_unit.sv =====
// particle euler step unit: sequencer, state, config registers and result register
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | op, dt, spawn position/velocity/colour/...
//  rsp     | out       | rsp_valid / rsp_ready | active, dead, updated particle state
//  csr     | in        | csr_wr_en             | csr_index, csr_wdata (64 bits)
//
// an active tick: a check state, 17 multiplies on the one shared 34x34 multiplier (each a
// multiply and a write-back state), a wait for the cordic angle, a post of the result. a
// delayed or unloaded tick goes from check to post. the cordic runs beside the multiplies.
// reset clears control state and sets config registers to defaults; the particle reads as not loaded.
// a finished item sits in the result register, and a new item is taken meanwhile.
`default_nettype none
module particle_euler_step_unit #(
   parameter int CORDIC_STEPS = pes_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_op,
   input  wire logic [15:0]        req_dt,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_vel_x,
   input  wire logic signed [31:0] req_vel_y,
   input  wire logic [31:0]        req_rgba,
   input  wire logic [15:0]        req_angle,
   input  wire logic signed [15:0] req_scale_x,
   input  wire logic signed [15:0] req_scale_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_active,
   output logic                    rsp_dead,
   output logic signed [31:0]      rsp_out_pos_x,
   output logic signed [31:0]      rsp_out_pos_y,
   output logic [31:0]             rsp_out_rgba,
   output logic [15:0]             rsp_out_angle,
   output logic signed [15:0]      rsp_out_scale_x,
   output logic signed [15:0]      rsp_out_scale_y,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);
   import pes_pkg::*;

   // config
   logic [31:0] lifetime_ff, start_delay_ff, slowdown_ff, rot_rate_ff;
   logic [63:0] gravity_ff, col_rates_ff, scl_rates_ff;
   logic        vel_rot_ff;

   // control
   state_type state_ff, state_in;
   step_type  step_ff;
   logic      loaded_ff, dead_ff, act_ff;

   // particle state
   logic signed [32:0] delay_ff;
   logic [31:0]        time_ff;
   logic signed [31:0] pos_ff [2];
   logic signed [31:0] vel_ff [2];
   logic signed [31:0] vtmp_ff [2];
   logic [7:0]         col_ff [4];
   logic [15:0]        rot_ff;
   logic signed [15:0] scl_ff [2];
   logic [15:0]        dt_ff;
   logic signed [47:0] q_ff;
   logic signed [65:0] acc_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_active_ff, rsp_dead_ff;
   logic signed [31:0] rsp_pos_x_ff, rsp_pos_y_ff;
   logic [31:0]        rsp_rgba_ff;
   logic [15:0]        rsp_angle_ff;
   logic signed [15:0] rsp_scale_x_ff, rsp_scale_y_ff;

   logic               accept, post;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod, pr15, pr23, pr31;
   logic               kidx;
   logic signed [33:0] nd, nd_cl;
   logic [32:0]        tsum;
   logic [31:0]        tnew;
   logic signed [65:0] dsum;
   logic signed [49:0] dval;
   cordic_ctl_type     cctl_in, cctl_out;
   logic [15:0]        cangle;

   pes_mul u_mul (
      .clock(clock),
      .mul_a(mul_a),
      .mul_b(mul_b),
      .prod(prod)
   );

   pes_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock),
      .reset(reset),
      .ctl_in(cctl_in),
      .vec_x(vel_ff[0]),
      .vec_y(vel_ff[1]),
      .ctl_out(cctl_out),
      .angle(cangle)
   );

   assign accept = req_valid && req_ready;
   assign post = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // delay countdown and time advance
   assign nd = 34'(delay_ff) - $signed({18'd0, dt_ff});
   assign nd_cl = (nd < -34'sd4294967296) ? -34'sd4294967296 : nd;
   assign tsum = {1'b0, time_ff} + 33'(dt_ff);
   assign tnew = tsum[32] ? 32'hffffffff : tsum[31:0];

   assign pr15 = prod + 68'sd32768;
   assign pr23 = prod + 68'sd8388608;
   assign pr31 = prod + 68'sd2147483648;
   assign dsum = acc_ff + 66'(prod) + 66'sd32768;
   assign dval = $signed(dsum[65:16]);

   always_comb begin
      kidx = (step_ff == STEP_SCY) || (step_ff == STEP_POSY) || (step_ff == STEP_GRAVY) ||
             (step_ff == STEP_SLOWY) || (step_ff == STEP_QHY) || (step_ff == STEP_QLY);
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = $signed({18'd0, dt_ff});
      unique case (step_ff)
         STEP_COL0: mul_a = 34'($signed(col_rates_ff[15:0]));
         STEP_COL1: mul_a = 34'($signed(col_rates_ff[31:16]));
         STEP_COL2: mul_a = 34'($signed(col_rates_ff[47:32]));
         STEP_COL3: mul_a = 34'($signed(col_rates_ff[63:48]));
         STEP_ROT: mul_a = 34'($signed(rot_rate_ff));
         STEP_SCX: mul_a = 34'($signed(scl_rates_ff[31:0]));
         STEP_SCY: mul_a = 34'($signed(scl_rates_ff[63:32]));
         STEP_POSX: mul_a = 34'(vel_ff[0]);
         STEP_POSY: mul_a = 34'(vel_ff[1]);
         STEP_GRAVX: mul_a = 34'($signed(gravity_ff[31:0]));
         STEP_GRAVY: mul_a = 34'($signed(gravity_ff[63:32]));
         STEP_SLOWX, STEP_SLOWY: begin
            mul_a = 34'(vtmp_ff[kidx]);
            mul_b = $signed({2'b00, slowdown_ff});
         end
         STEP_QHX, STEP_QHY: mul_a = 34'($signed(q_ff[47:24]));
         STEP_QLX, STEP_QLY: mul_a = $signed({10'd0, q_ff[23:0]});
         default: mul_a = '0;
      endcase
   end

   // next state and outputs
   always_comb begin
      state_in = state_ff;
      req_ready = (state_ff == ST_IDLE);
      cctl_in.start = 1'b0;
      cctl_in.busy = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!loaded_ff || (!nd_cl[33] && nd_cl != 34'sd0)) begin
               state_in = ST_FINISH;
            end else begin
               cctl_in.start = vel_rot_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_WB;
         ST_WB: state_in = (step_ff == STEP_QLY) ? ST_WAITC : ST_MUL;
         ST_WAITC: begin
            if (!cctl_out.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (post) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= 32'd65536;
         start_delay_ff <= '0;
         gravity_ff <= '0;
         slowdown_ff <= '0;
         rot_rate_ff <= '0;
         col_rates_ff <= '0;
         scl_rates_ff <= '0;
         vel_rot_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LIFETIME: lifetime_ff <= csr_wdata[31:0];
            CSR_START_DELAY: start_delay_ff <= csr_wdata[31:0];
            CSR_GRAVITY_XY: gravity_ff <= csr_wdata;
            CSR_SLOWDOWN: slowdown_ff <= csr_wdata[31:0];
            CSR_ROTATION_RATE: rot_rate_ff <= csr_wdata[31:0];
            CSR_COLOR_RATES: col_rates_ff <= csr_wdata;
            CSR_SCALE_RATES: scl_rates_ff <= csr_wdata;
            CSR_VEL_AS_ROT: vel_rot_ff <= csr_wdata[0];
            default: vel_rot_ff <= vel_rot_ff;
         endcase
      end
   end

   // particle state and sequencer datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         dead_ff <= 1'b0;
         act_ff <= 1'b0;
         delay_ff <= '0;
         time_ff <= '0;
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         vel_ff[0] <= '0;
         vel_ff[1] <= '0;
         col_ff[0] <= '0;
         col_ff[1] <= '0;
         col_ff[2] <= '0;
         col_ff[3] <= '0;
         rot_ff <= '0;
         scl_ff[0] <= '0;
         scl_ff[1] <= '0;
         step_ff <= STEP_COL0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  dt_ff <= req_op ? 16'd0 : req_dt;
                  if (req_op) begin
                     loaded_ff <= 1'b1;
                     dead_ff <= 1'b0;
                     time_ff <= '0;
                     delay_ff <= $signed({1'b0, start_delay_ff});
                     pos_ff[0] <= req_pos_x;
                     pos_ff[1] <= req_pos_y;
                     vel_ff[0] <= req_vel_x;
                     vel_ff[1] <= req_vel_y;
                     col_ff[0] <= req_rgba[7:0];
                     col_ff[1] <= req_rgba[15:8];
                     col_ff[2] <= req_rgba[23:16];
                     col_ff[3] <= req_rgba[31:24];
                     rot_ff <= req_angle;
                     scl_ff[0] <= req_scale_x;
                     scl_ff[1] <= req_scale_y;
                  end
               end
            end
            ST_CHECK: begin
               step_ff <= STEP_COL0;
               act_ff <= 1'b0;
               if (!loaded_ff) begin
                  dead_ff <= 1'b1;
               end else begin
                  delay_ff <= nd_cl[32:0];
                  if (nd_cl[33] || nd_cl == 34'sd0) begin
                     act_ff <= 1'b1;
                     time_ff <= tnew;
                     if (tnew >= lifetime_ff) begin
                        dead_ff <= 1'b1;
                     end
                  end
               end
            end
            ST_MUL: begin
               step_ff <= step_ff;
            end
            ST_WB: begin
               if (step_ff != STEP_QLY) begin
                  step_ff <= step_type'(step_ff + 5'd1);
               end
               unique case (step_ff)
                  STEP_COL0, STEP_COL1, STEP_COL2, STEP_COL3: begin
                     col_ff[step_ff[1:0]] <= clamp8($signed({4'd0, col_ff[step_ff[1:0]]})
                                                    + $signed(pr23[35:24]));
                  end
                  STEP_ROT: rot_ff <= rot_ff + pr31[47:32];
                  STEP_SCX, STEP_SCY: begin
                     scl_ff[kidx] <= sat16(26'(scl_ff[kidx]) + $signed(pr23[49:24]));
                  end
                  STEP_POSX, STEP_POSY: begin
                     pos_ff[kidx] <= sat32(51'(pos_ff[kidx]) + 51'($signed(pr15[48:16])));
                  end
                  STEP_GRAVX, STEP_GRAVY: begin
                     vtmp_ff[kidx] <= sat32(51'(vel_ff[kidx]) + 51'($signed(pr15[48:16])));
                  end
                  STEP_SLOWX, STEP_SLOWY: q_ff <= $signed(pr15[63:16]);
                  STEP_QHX, STEP_QHY: acc_ff <= $signed({prod[41:0], 24'd0});
                  STEP_QLX, STEP_QLY: begin
                     vel_ff[kidx] <= sat32(51'(vtmp_ff[kidx]) - 51'(dval));
                  end
                  default: acc_ff <= acc_ff;
               endcase
            end
            ST_WAITC: begin
               // heading replaces the ramped rotation
               if (!cctl_out.busy && vel_rot_ff) begin
                  rot_ff <= cangle - QUARTER_TURN;
               end
            end
            ST_FINISH: begin
               step_ff <= STEP_COL0;
            end
            default: step_ff <= STEP_COL0;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (post) begin
         rsp_active_ff <= act_ff;
         rsp_dead_ff <= dead_ff;
         rsp_pos_x_ff <= pos_ff[0];
         rsp_pos_y_ff <= pos_ff[1];
         rsp_rgba_ff <= {col_ff[3], col_ff[2], col_ff[1], col_ff[0]};
         rsp_angle_ff <= rot_ff;
         rsp_scale_x_ff <= scl_ff[0];
         rsp_scale_y_ff <= scl_ff[1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_dead = rsp_dead_ff;
   assign rsp_out_pos_x = rsp_pos_x_ff;
   assign rsp_out_pos_y = rsp_pos_y_ff;
   assign rsp_out_rgba = rsp_rgba_ff;
   assign rsp_out_angle = rsp_angle_ff;
   assign rsp_out_scale_x = rsp_scale_x_ff;
   assign rsp_out_scale_y = rsp_scale_y_ff;
endmodule
`default_nettype wire

// ===== bench/pes_checker.sv =====
// result checker of the particle euler step unit: watches request, result and csr channels and predicts results
`timescale 1ns / 100ps
module pes_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_op,
   input  wire logic [15:0]        req_dt,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_vel_x,
   input  wire logic signed [31:0] req_vel_y,
   input  wire logic [31:0]        req_rgba,
   input  wire logic [15:0]        req_angle,
   input  wire logic signed [15:0] req_scale_x,
   input  wire logic signed [15:0] req_scale_y,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               rsp_active,
   input  wire logic               rsp_dead,
   input  wire logic signed [31:0] rsp_out_pos_x,
   input  wire logic signed [31:0] rsp_out_pos_y,
   input  wire logic [31:0]        rsp_out_rgba,
   input  wire logic [15:0]        rsp_out_angle,
   input  wire logic signed [15:0] rsp_out_scale_x,
   input  wire logic signed [15:0] rsp_out_scale_y,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata,
   output int                      fail_count,
   output int                      pending_count,
   output int                      rsp_count,
   output int                      active_count
);
   import pes_pkg::*;

   typedef struct packed {
      logic        active;
      logic        dead;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] rgba;
      logic [15:0] angle;
      logic [15:0] scale_x;
      logic [15:0] scale_y;
   } particle_view_type;

   particle_view_type view_q[$];

   logic [31:0] lifetime_r, start_delay_r, slowdown_r;
   logic [63:0] gravity_r, color_rates_r, scale_rates_r;
   longint      rot_rate_r;
   logic        vel_rot_r;

   logic   is_loaded, is_dead;
   longint delay_cnt, pos[2], vel[2], scl[2];
   longint life_time;
   int     col[4];
   logic [15:0] rot;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic logic [15:0] atan_lut(int i);
      int t[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
      return 16'(t[i]);
   endfunction

   function automatic logic [15:0] vector_angle(longint y, longint x);
      logic [15:0] z;
      longint xs, ys;
      z = 16'd0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = HALF_TURN;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += atan_lut(i);
         end else begin
            x -= ys; y += xs; z -= atan_lut(i);
         end
      end
      return z;
   endfunction

   function automatic logic advance(longint dt);
      longint nd, c, v, d, g, rate;
      if (!is_loaded) begin
         is_dead = 1'b1;
         return 1'b0;
      end
      nd = delay_cnt - dt;
      delay_cnt = nd < -64'sd4294967296 ? -64'sd4294967296 : nd;
      if (delay_cnt > 0) return 1'b0;
      life_time = life_time + dt > 64'hFFFFFFFF ? 64'hFFFFFFFF : life_time + dt;
      if (life_time >= lifetime_r) is_dead = 1'b1;
      for (int k = 0; k < 4; k++) begin
         rate = longint'($signed(color_rates_r[16*k +: 16]));
         c = round_shift((longint'(col[k]) <<< 24) + rate * dt, 24);
         col[k] = c < 0 ? 0 : (c > 255 ? 255 : int'(c));
      end
      rot = rot + 16'(round_shift(rot_rate_r * dt, 32));
      for (int k = 0; k < 2; k++) begin
         rate = longint'($signed(scale_rates_r[32*k +: 32]));
         scl[k] = clip(scl[k] + round_shift(rate * dt, 24), 16);
      end
      if (vel_rot_r) rot = vector_angle(vel[1], vel[0]) - QUARTER_TURN;
      for (int k = 0; k < 2; k++) begin
         g = longint'($signed(gravity_r[32*k +: 32]));
         pos[k] = clip(pos[k] + round_shift(vel[k] * dt, 16), 32);
         v = clip(vel[k] + round_shift(g * dt, 16), 32);
         d = round_shift(round_shift(v * longint'(slowdown_r), 16) * dt, 16);
         vel[k] = clip(v - d, 32);
      end
      return 1'b1;
   endfunction

   particle_view_type got, want;
   logic act;

   always @(posedge clock) begin
      if (reset) begin
         lifetime_r <= 32'h10000; start_delay_r <= '0; slowdown_r <= '0;
         gravity_r <= '0; color_rates_r <= '0; scale_rates_r <= '0;
         rot_rate_r <= 0; vel_rot_r <= 1'b0;
         is_loaded = 0; is_dead = 0; delay_cnt = 0; life_time = 0;
         pos = '{0, 0}; vel = '{0, 0}; scl = '{0, 0}; col = '{0, 0, 0, 0}; rot = 0;
         view_q.delete();
         fail_count <= 0; rsp_count <= 0; active_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_LIFETIME:      lifetime_r <= csr_wdata[31:0];
               CSR_START_DELAY:   start_delay_r <= csr_wdata[31:0];
               CSR_GRAVITY_XY:    gravity_r <= csr_wdata;
               CSR_SLOWDOWN:      slowdown_r <= csr_wdata[31:0];
               CSR_ROTATION_RATE: rot_rate_r <= longint'($signed(csr_wdata[31:0]));
               CSR_COLOR_RATES:   color_rates_r <= csr_wdata;
               CSR_SCALE_RATES:   scale_rates_r <= csr_wdata;
               CSR_VEL_AS_ROT:    vel_rot_r <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_op) begin
               is_loaded = 1; is_dead = 0; life_time = 0;
               delay_cnt = longint'(start_delay_r);
               pos[0] = req_pos_x; pos[1] = req_pos_y;
               vel[0] = req_vel_x; vel[1] = req_vel_y;
               for (int k = 0; k < 4; k++) col[k] = req_rgba[8*k +: 8];
               rot = req_angle; scl[0] = req_scale_x; scl[1] = req_scale_y;
               act = advance(0);
            end else begin
               act = advance(longint'(req_dt));
            end
            view_q.push_back('{act, is_dead, pos[0][31:0], pos[1][31:0],
               {col[3][7:0], col[2][7:0], col[1][7:0], col[0][7:0]}, rot,
               scl[0][15:0], scl[1][15:0]});
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_active, rsp_dead, rsp_out_pos_x, rsp_out_pos_y, rsp_out_rgba,
               rsp_out_angle, rsp_out_scale_x, rsp_out_scale_y};
            rsp_count <= rsp_count + 1;
            if (rsp_active) active_count <= active_count + 1;
            if (view_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected item: %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = view_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) $display("mismatch\n exp %p\n got %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = view_q.size();
endmodule

// ===== bench/tb_top.sv =====
// testbench top of the particle euler step unit: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
module tb_top;
   import pes_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready, req_op = 1'b0;
   logic [15:0] req_dt = '0, req_angle = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_vel_x = '0, req_vel_y = '0;
   logic [31:0] req_rgba = '0;
   logic signed [15:0] req_scale_x = '0, req_scale_y = '0;
   logic rsp_valid, rsp_ready = 1'b0, rsp_active, rsp_dead;
   logic signed [31:0] rsp_out_pos_x, rsp_out_pos_y;
   logic [31:0] rsp_out_rgba;
   logic [15:0] rsp_out_angle;
   logic signed [15:0] rsp_out_scale_x, rsp_out_scale_y;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;
   int fail_count, pending_count, rsp_count, active_count;
   logic calm = 1'b0;
   logic zero_vel = 1'b0;
   int item_count = 0;

   always #4 clock = ~clock;

   particle_euler_step_unit u_top (.*);
   pes_checker u_checker (.*);

   // result side stalls in bursts
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 20000)) - 10000) <<< $urandom_range(0, 16);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(logic op, logic [15:0] dt);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 9);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_dt <= dt;
      req_pos_x <= pick_word();
      req_pos_y <= pick_word();
      req_vel_x <= zero_vel ? 32'sd0 : pick_word();
      req_vel_y <= zero_vel ? 32'sd0 : pick_word();
      req_rgba <= $urandom();
      req_angle <= 16'($urandom());
      req_scale_x <= 16'($urandom());
      req_scale_y <= 16'($urandom());
      // ready is stable at the falling edge, so the next rising edge takes the item
      while (!req_ready) @(negedge clock);
      @(negedge clock);
      item_count++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   // one random register setting, extremes now and then
   task automatic configure(bit extreme);
      write_reg(CSR_LIFETIME, extreme ? {32'h0, 32'hffffffff} :
         64'($urandom_range(0, 200000)));
      write_reg(CSR_START_DELAY, extreme ? 64'h0 : 64'($urandom_range(0, 40000)));
      write_reg(CSR_GRAVITY_XY, extreme ? 64'h7fffffff_80000000 : {pick_word(), pick_word()});
      write_reg(CSR_SLOWDOWN, extreme ? 64'hffffffff : 64'($urandom_range(0, 1 << 17)));
      write_reg(CSR_ROTATION_RATE, extreme ? 64'h80000000 : {32'h0, pick_word()});
      write_reg(CSR_COLOR_RATES, {$urandom(), $urandom()});
      write_reg(CSR_SCALE_RATES, extreme ? 64'h80000000_7fffffff : {pick_word(), pick_word()});
      write_reg(CSR_VEL_AS_ROT, 64'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // ticks with nothing loaded, then extremes of dt around spawns
      send_item(1'b0, 16'hffff);
      send_item(1'b0, 16'h0000);
      settle();
      write_reg(CSR_START_DELAY, 64'h18000);
      write_reg(CSR_LIFETIME, 64'h0);
      send_item(1'b1, 16'h0);
      repeat (3) send_item(1'b0, 16'hffff);
      send_item(1'b0, 16'h0);
      settle();
      configure(1'b1);
      send_item(1'b1, 16'h0);
      repeat (4) send_item(1'b0, 16'hffff);
      send_item(1'b0, 16'h1);
      settle();
      write_reg(CSR_VEL_AS_ROT, 64'h1);
      write_reg(CSR_START_DELAY, 64'h0);
      zero_vel = 1'b1;
      send_item(1'b1, 16'h0);
      zero_vel = 1'b0;
      send_item(1'b0, 16'h8000);
      settle();
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 10) calm = 1'b1;
         configure(ph == 5);
         for (int n = 0; n < 88; n++)
            send_item($urandom_range(0, 11) == 0, $urandom_range(0, 3) == 0 ?
               16'hffff : 16'($urandom()));
         settle();
      end
      $display("items sent %0d, results checked %0d, %0d of them active", item_count,
         rsp_count, active_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end
endmodule
